[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

[rtl/core/lrukv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
package lrukv_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_PUT = 1'b0,
    CMD_GET = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } rsp_t;

endpackage

[rtl/core/lrukv_core.sv]
// Entry store, parallel key match and recency rank update for one item per cycle on which fire is high.
module lrukv_core import lrukv_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  req_t             req,
  input  logic [CFG_W-1:0] active_capacity,
  output rsp_t             rsp
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [KEY_BITS-1:0]   key_r [CAPACITY];
  logic [VALUE_BITS-1:0] val_r [CAPACITY];
  logic [RANK_W-1:0]     rank_r [CAPACITY];
  logic [RANK_W-1:0]     rank_nxt [CAPACITY];
  logic [CAPACITY-1:0]   valid_r, valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;
  logic [CAPACITY-1:0]   match, hit_oh, free_oh, victim_oh, target_oh;
  logic [CNT_W-1:0]      cnt_m1;
  logic [RANK_W-1:0]     last_rank, tgt_rank;
  logic [CMP_W-1:0]      cap_ext, eff_cap;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  hit, is_get, room, act, insert;

  always_comb begin
    key_in  = KEY_BITS'(req.key);
    val_in  = VALUE_BITS'(req.value);
    is_get  = (req.cmd == CMD_GET);
    cnt_m1  = count_r - CNT_W'(1);
    last_rank = cnt_m1[RANK_W-1:0];

    for (int j = 0; j < CAPACITY; j++) begin
      match[j]     = valid_r[j] && (key_r[j] == key_in);
      victim_oh[j] = valid_r[j] && (rank_r[j] == last_rank);
    end
    hit     = |match;
    hit_oh  = match & (~match + CAPACITY'(1));
    free_oh = ~valid_r & (valid_r + CAPACITY'(1));

    // Clamp the capacity register into 1..CAPACITY.
    cap_ext = CMP_W'(active_capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      eff_cap = CMP_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
    room = CMP_W'(count_r) < eff_cap;

    act       = fire && (hit || !is_get);
    insert    = act && !hit && room;
    target_oh = hit ? hit_oh : (room ? free_oh : victim_oh);

    tgt_rank = '0;
    rd_val   = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (target_oh[j]) tgt_rank = tgt_rank | rank_r[j];
      if (hit_oh[j])    rd_val   = rd_val | val_r[j];
    end

    // Age every valid entry more recent than the target; an insert ages them all.
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int j = 0; j < CAPACITY; j++) begin
      rank_nxt[j] = rank_r[j];
      if (act) begin
        if (target_oh[j]) begin
          rank_nxt[j] = '0;
        end else if (valid_r[j] && (insert || (rank_r[j] < tgt_rank))) begin
          rank_nxt[j] = rank_r[j] + RANK_W'(1);
        end
      end
    end
    if (insert) begin
      valid_nxt = valid_r | free_oh;
      count_nxt = count_r + CNT_W'(1);
    end

    rsp.hit        = hit;
    rsp.read_value = (hit && is_get) ? DATA_W'(rd_val) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int j = 0; j < CAPACITY; j++) begin
        rank_r[j] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int j = 0; j < CAPACITY; j++) begin
        rank_r[j] <= rank_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CAPACITY; j++) begin
      if (act && target_oh[j] && !hit) key_r[j] <= key_in;
      if (act && target_oh[j] && !is_get) val_r[j] <= val_in;
    end
  end

endmodule

[rtl/core/lru_key_value_cache.sv]
// Top level of the LRU key-value cache: handshakes, capacity register, input register and result register.
//
// Fully associative key-value store with least-recently-used replacement.
// Each item is a put (cmd 0) or a get (cmd 1); every item gives exactly one
// result: hit tells whether the key was held before the item, and
// read_value carries the stored value on a get that hits and zero otherwise.
// A put that misses fills the lowest free slot while fewer entries are held
// than the active capacity, otherwise it overwrites the least recent entry.
// The capacity register clamps to 1..CAPACITY; lowering it below the number
// of entries held keeps them all, and later misses replace in place. Write
// it only while no item is in flight. Throughput is one item per clock while the
// result channel does not stall: the key compare across all entries, the rank
// update and the store write are done combinationally between the input register
// and the result register, so an item sees everything the previous one left. An
// accepted item waits in the input register and its result in the result register,
// which drives out_valid. The entry store needs no clearing pass after reset;
// only the valid bits, ranks and fill count reset.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input item channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [KEY_W-1:0]         in_key,
  input  logic signed [DATA_W-1:0] in_value,
  // result item channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  // capacity register write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_active_capacity
);

  logic             in_vld_r, in_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  req_t             req_r;
  rsp_t             rsp_r, rsp;
  logic [CFG_W-1:0] cap_r, cap_nxt;
  logic             advance, fire, in_take;

  // The result register frees up when empty or being drained this cycle;
  // the input register then hands its item to the core.
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;
  assign in_take  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end

    cap_nxt = cfg_valid ? cfg_active_capacity : cap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cap_r     <= CAP_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      cap_r     <= cap_nxt;
    end
  end

  // Hold payloads until the matching handshake moves the item on.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.cmd   <= cmd_t'(in_cmd);
      req_r.key   <= in_key;
      req_r.value <= in_value;
    end
    if (fire) begin
      rsp_r <= rsp;
    end
  end

  lrukv_core #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .req             (req_r),
    .active_capacity (cap_r),
    .rsp             (rsp)
  );

  assign out_valid      = out_vld_r;
  assign out_hit        = rsp_r.hit;
  assign out_read_value = $signed(rsp_r.read_value);

endmodule

[rtl/core/lrukv_checker.sv]
// Port-level assertions for the LRU key-value cache and their bind.
`include "assert_macros.svh"

module lrukv_checker import lrukv_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_hit,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic                     cfg_ready
);

  logic            in_take;
  logic            out_stall;
  logic [DATA_W:0] out_payload;

  assign in_take     = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {out_hit, out_read_value};

  `ASSERT_CLK(a_out_hold, out_stall |=> out_valid && $stable(out_payload), "result moved in stall")

  `ASSERT_NEVER(a_miss_zero, out_valid && !out_hit && (out_read_value != '0), "miss carries a value")

  `ASSERT_CLK(a_ready_follow, out_ready |-> in_ready, "input stalled with output draining")

  `ASSERT_CLK(a_two_cycle, in_take ##1 out_ready |=> out_valid, "no result after accept")

  `ASSERT_NEVER(a_cfg_ready, !cfg_ready, "capacity write refused")

endmodule

bind lru_key_value_cache lrukv_checker u_checker (.*);
